// ===== rtl/pfbr_pkg.sv =====
// Shared types and constants of the packet framed byte ring.
package pfbr_pkg;

   localparam int unsigned MODE_W      = 2;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned PLEN_W      = 13;
   localparam int unsigned STATUS_W    = 3;
   localparam int unsigned COUNT_W     = 13;
   localparam int unsigned REMAIN_W    = 32;
   localparam int unsigned LEN_BYTES   = 4;
   localparam int unsigned REQ_DATA_W  = 24;
   localparam int unsigned REQ_USER_W  = 2;
   localparam int unsigned RSP_DATA_W  = 72;
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 1;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH  = 2'd0,
      MODE_POP   = 2'd1,
      MODE_BEGIN = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_NO_SPACE = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_CLOSED   = 3'd3,
      ST_STREAM   = 3'd4
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PACKET_MODE = 1'd0,
      CSR_LINK_OPEN   = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [REMAIN_W-1:0] packet_remaining;
      logic [COUNT_W-1:0]  writable;
      logic [COUNT_W-1:0]  readable;
      logic [BYTE_W-1:0]   read_byte;
      status_type          status;
   } result_type;

   typedef struct packed {
      logic idle;
      logic emit;
   } ctrl_status_type;

endpackage

// ===== rtl/pfbr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module pfbr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/pfbr_ctrl.sv =====
// Sequencer of the byte ring: pointers, pending length and the ring memory.
module pfbr_ctrl
   import pfbr_pkg::*;
#(
   parameter int unsigned BUF_BYTES    = 8192,
   parameter int unsigned HEADER_BYTES = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  mode_type          mode,
   input  logic [BYTE_W-1:0] payload_byte,
   input  logic [PLEN_W-1:0] packet_length,
   input  logic              packet_mode,
   input  logic              link_open,
   input  logic              out_free,
   output ctrl_status_type   ctrl_status,
   output result_type        result
);

   localparam int unsigned PTR_W = $clog2(BUF_BYTES);
   localparam int unsigned CNT_W = $clog2(HEADER_BYTES + 1);
   localparam int unsigned CMP_W = ((PTR_W > PLEN_W) ? PTR_W : PLEN_W) + 2;
   localparam logic [PTR_W-1:0] MASK  = PTR_W'(BUF_BYTES - 1);
   localparam logic [PTR_W-1:0] HDR_P = PTR_W'(HEADER_BYTES);
   localparam logic [CMP_W-1:0] HDR_C = CMP_W'(HEADER_BYTES);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_STRIP = 6'b000010,
      S_OP    = 6'b000100,
      S_POPW  = 6'b001000,
      S_HDRW  = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [PTR_W-1:0]    wp_ff, wp_in;
   logic [PTR_W-1:0]    rp_ff, rp_in;
   logic [REMAIN_W-1:0] pend_ff, pend_in;
   logic [REMAIN_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                post_ff, post_in;
   mode_type            mode_ff, mode_in;
   logic [BYTE_W-1:0]   byte_ff, byte_in;
   logic [PLEN_W-1:0]   plen_ff, plen_in;
   status_type          status_ff, status_in;
   logic [BYTE_W-1:0]   rbyte_ff, rbyte_in;

   logic [PTR_W-1:0]    held, free, rd_cnt, wr_cnt;
   logic [CMP_W-1:0]    held_c, free_c, need_c;
   logic                strip_ok, pop_ok, begin_fit;
   logic [1:0]          cap_idx;
   logic [REMAIN_W-1:0] plen32;
   logic [BYTE_W-1:0]   hdr_byte;

   logic                ram_we, ram_re;
   logic [PTR_W-1:0]    ram_waddr, ram_raddr;
   logic [BYTE_W-1:0]   ram_wdata, ram_rdata;

   pfbr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUF_BYTES)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign held      = wp_ff - rp_ff;
   assign free      = MASK - held;
   assign held_c    = CMP_W'(held);
   assign free_c    = CMP_W'(free);
   assign need_c    = CMP_W'(plen_ff) + HDR_C;
   assign strip_ok  = packet_mode && (pend_ff == '0) && (held_c >= HDR_C);
   assign pop_ok    = (held != '0) && (!packet_mode || (pend_ff != '0));
   assign begin_fit = free_c >= need_c;
   assign cap_idx   = 2'(cnt_ff - CNT_W'(1));
   assign plen32    = REMAIN_W'(plen_ff);
   assign hdr_byte  = (cnt_ff < CNT_W'(LEN_BYTES)) ? plen32[8*cnt_ff[1:0] +: 8] : '0;

   // Result counts; packet mode caps reads at the pending packet, writes less a header.
   always_comb begin
      rd_cnt = held;
      wr_cnt = free;
      if (packet_mode) begin
         if (pend_ff < REMAIN_W'(held)) begin
            rd_cnt = pend_ff[PTR_W-1:0];
         end
         wr_cnt = (free_c > HDR_C) ? (free - HDR_P) : '0;
      end
   end

   always_comb begin
      state_in  = state_ff;
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      pend_in   = pend_ff;
      len_in    = len_ff;
      cnt_in    = cnt_ff;
      post_in   = post_ff;
      mode_in   = mode_ff;
      byte_in   = byte_ff;
      plen_in   = plen_ff;
      status_in = status_ff;
      rbyte_in  = rbyte_ff;
      ram_we    = 1'b0;
      ram_waddr = wp_ff;
      ram_wdata = byte_ff;
      ram_re    = 1'b0;
      ram_raddr = rp_ff;
      ctrl_status.idle = (state_ff == S_IDLE);
      ctrl_status.emit = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in   = mode;
               byte_in   = payload_byte;
               plen_in   = packet_length;
               status_in = ST_OK;
               rbyte_in  = '0;
               post_in   = 1'b0;
               cnt_in    = '0;
               state_in  = strip_ok ? S_STRIP : S_OP;
            end
         end
         S_STRIP: begin
            // Only the four length bytes are fetched; the rest of the header is skipped.
            if (cnt_ff < CNT_W'(LEN_BYTES)) begin
               ram_re    = 1'b1;
               ram_raddr = rp_ff + PTR_W'(cnt_ff[1:0]);
            end
            if (cnt_ff != '0) begin
               len_in[8*cap_idx +: 8] = ram_rdata;
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(LEN_BYTES)) begin
               rp_in    = rp_ff + HDR_P;
               pend_in  = len_in;
               cnt_in   = '0;
               state_in = post_ff ? S_DONE : S_OP;
            end
         end
         S_OP: begin
            state_in = S_DONE;
            case (mode_ff)
               MODE_PUSH: begin
                  if (!link_open) begin
                     status_in = ST_CLOSED;
                  end else if (free == '0) begin
                     status_in = ST_NO_SPACE;
                  end else begin
                     ram_we = 1'b1;
                     wp_in  = wp_ff + PTR_W'(1);
                  end
               end
               MODE_POP: begin
                  if (!pop_ok) begin
                     status_in = ST_EMPTY;
                  end else begin
                     ram_re   = 1'b1;
                     rp_in    = rp_ff + PTR_W'(1);
                     state_in = S_POPW;
                     if (packet_mode) begin
                        pend_in = pend_ff - REMAIN_W'(1);
                     end
                  end
               end
               MODE_BEGIN: begin
                  if (!packet_mode) begin
                     status_in = ST_STREAM;
                  end else if (!link_open) begin
                     status_in = ST_CLOSED;
                  end else if (!begin_fit) begin
                     status_in = ST_NO_SPACE;
                  end else begin
                     cnt_in   = '0;
                     state_in = S_HDRW;
                  end
               end
               default: begin
               end
            endcase
         end
         S_POPW: begin
            rbyte_in = ram_rdata;
            state_in = S_DONE;
         end
         S_HDRW: begin
            ram_we    = 1'b1;
            ram_wdata = hdr_byte;
            wp_in     = wp_ff + PTR_W'(1);
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(HEADER_BYTES - 1)) begin
               cnt_in   = '0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!post_ff && strip_ok) begin
               post_in  = 1'b1;
               cnt_in   = '0;
               state_in = S_STRIP;
            end else if (out_free) begin
               ctrl_status.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign result.status           = status_ff;
   assign result.read_byte        = rbyte_ff;
   assign result.readable         = COUNT_W'(rd_cnt);
   assign result.writable         = COUNT_W'(wr_cnt);
   assign result.packet_remaining = pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wp_ff    <= '0;
         rp_ff    <= '0;
         pend_ff  <= '0;
         cnt_ff   <= '0;
         post_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         pend_ff  <= pend_in;
         cnt_ff   <= cnt_in;
         post_ff  <= post_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff    <= len_in;
      mode_ff   <= mode_in;
      byte_ff   <= byte_in;
      plen_ff   <= plen_in;
      status_ff <= status_in;
      rbyte_ff  <= rbyte_in;
   end

`ifndef NO_ASSERTIONS
   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (held != MASK))
      else $error("ring written while full");

   a_single_access: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("ring read and written in the same cycle");

   a_pop_data_follows_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POPW) |-> $past(ram_re))
      else $error("pop capture without a preceding read");

   a_pending_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (pend_ff != $past(pend_ff))) |->
      ($past(state_ff) == S_STRIP || $past(state_ff) == S_OP))
      else $error("pending length changed outside strip or pop");
`endif

endmodule

// ===== rtl/packet_framed_byte_ring_top.sv =====
// Top level of the packet framed byte ring: channels, registers and result stage.
//
// Use: each request beat carries one command in req_tuser (push byte, pop
// byte, begin packet) with its operands in req_tdata. Every request gives
// exactly one response beat on rsp_tdata with a status, the byte popped and
// the readable, writable and pending packet counts after the command.
// Registers packet_mode (index 0) and link_open (index 1) are written
// through csr_we/csr_index/csr_wdata; the user must write them only while
// no command is in flight, as the block itself does not enforce it.
// Each command passes the operate and done states to the response register;
// a successful pop adds a ring read state, a packet start writes its header
// one byte per cycle on the single ring write port, and each header strip in
// packet mode fetches the 32-bit length. One command is worked on at a time.
// Reset clears the pointers, the pending length and both registers; the ring
// contents are not cleared. When the receiver stalls, the response waits in
// the output register and the next request is still accepted and worked on
// up to its own response, which then waits for the register to free.
module packet_framed_byte_ring_top
   import pfbr_pkg::*;
#(
   parameter int unsigned BUF_BYTES    = 8192,
   parameter int unsigned HEADER_BYTES = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // payload_byte, packet_length, zero pad
   input  logic [REQ_USER_W-1:0]  req_tuser,   // mode
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // status, read_byte, readable,
                                               // writable, packet_remaining, zero pad
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic            packet_mode_ff, packet_mode_in;
   logic            link_open_ff, link_open_in;
   logic            rsp_valid_ff, rsp_valid_in;
   result_type      rsp_data_ff, rsp_data_in;
   ctrl_status_type ctrl_status;
   result_type      result;
   logic            out_free;
   logic            start;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = ctrl_status.idle;
   assign start      = req_tvalid && req_tready;

   pfbr_ctrl #(
      .BUF_BYTES    (BUF_BYTES),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .mode          (mode_type'(req_tuser)),
      .payload_byte  (req_tdata[BYTE_W-1:0]),
      .packet_length (req_tdata[BYTE_W +: PLEN_W]),
      .packet_mode   (packet_mode_ff),
      .link_open     (link_open_ff),
      .out_free      (out_free),
      .ctrl_status   (ctrl_status),
      .result        (result)
   );

   always_comb begin
      packet_mode_in = packet_mode_ff;
      link_open_in   = link_open_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PACKET_MODE: packet_mode_in = csr_wdata[0];
            CSR_LINK_OPEN:   link_open_in   = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl_status.emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_mode_ff <= 1'b0;
         link_open_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         packet_mode_ff <= packet_mode_in;
         link_open_ff   <= link_open_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the packet framed byte ring, with a built-in predictor of the ring.
module tb_top
   import pfbr_pkg::*;
();

   localparam int unsigned RING_SIZE   = 8192;
   localparam int unsigned HEADER_LEN  = 20;
   localparam int unsigned MAX_PLEN    = 8171;
   localparam int unsigned IDLE_CYCLES = 40;

   // Predicts every response beat from the accepted request beats and checks the real ones.
   class ring_scoreboard;
      logic [BYTE_W-1:0]   ring_bytes [RING_SIZE];
      logic [COUNT_W-1:0]  wr_ptr;
      logic [COUNT_W-1:0]  rd_ptr;
      logic [REMAIN_W-1:0] pending_len;
      bit                  packet_mode;
      bit                  link_open;
      result_type          expected_q [$];
      int unsigned         errors;

      function new();
         foreach (ring_bytes[i]) ring_bytes[i] = '0;
         wr_ptr      = '0;
         rd_ptr      = '0;
         pending_len = '0;
         packet_mode = 1'b0;
         link_open   = 1'b0;
         errors      = 0;
      endfunction

      function int unsigned held();
         logic [COUNT_W-1:0] diff;
         diff = wr_ptr - rd_ptr;
         return diff;
      endfunction

      function int unsigned free_bytes();
         return RING_SIZE - 1 - held();
      endfunction

      function void put_byte(logic [BYTE_W-1:0] b);
         ring_bytes[wr_ptr] = b;
         wr_ptr = wr_ptr + 1'b1;
      endfunction

      function logic [BYTE_W-1:0] take_byte();
         logic [BYTE_W-1:0] b;
         b = ring_bytes[rd_ptr];
         rd_ptr = rd_ptr + 1'b1;
         return b;
      endfunction

      // A header is consumed only in packet mode, when no packet is pending and a whole one is held.
      function void strip_header();
         logic [REMAIN_W-1:0] len_word;
         logic [BYTE_W-1:0]   b;
         len_word = '0;
         if (!packet_mode || pending_len != 0 || held() < HEADER_LEN) return;
         for (int i = 0; i < HEADER_LEN; i++) begin
            b = take_byte();
            if (i < LEN_BYTES) len_word[8*i +: 8] = b;
         end
         pending_len = len_word;
      endfunction

      function void set_register(csr_index_type idx, bit value);
         if (idx == CSR_PACKET_MODE) packet_mode = value;
         else link_open = value;
      endfunction

      function status_type note_request(mode_type mode, logic [BYTE_W-1:0] pbyte,
                                        logic [PLEN_W-1:0] plen);
         result_type          r;
         int unsigned         avail;
         int unsigned         rd_count;
         int unsigned         wr_count;
         logic [REMAIN_W-1:0] len_word;
         r = '0;
         r.status = ST_OK;
         len_word = plen;
         strip_header();
         case (mode)
            MODE_PUSH: begin
               if (!link_open) r.status = ST_CLOSED;
               else if (free_bytes() == 0) r.status = ST_NO_SPACE;
               else put_byte(pbyte);
            end
            MODE_POP: begin
               avail = held();
               if (packet_mode && avail > pending_len) avail = pending_len;
               if (avail == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  r.read_byte = take_byte();
                  if (packet_mode) pending_len = pending_len - 1;
               end
            end
            MODE_BEGIN: begin
               if (!packet_mode) r.status = ST_STREAM;
               else if (!link_open) r.status = ST_CLOSED;
               else if (free_bytes() < plen + HEADER_LEN) r.status = ST_NO_SPACE;
               else begin
                  for (int i = 0; i < HEADER_LEN; i++) begin
                     if (i < LEN_BYTES) put_byte(len_word[8*i +: 8]);
                     else put_byte(8'h00);
                  end
               end
            end
            default: ;
         endcase
         strip_header();
         rd_count = held();
         wr_count = free_bytes();
         if (packet_mode) begin
            if (rd_count > pending_len) rd_count = pending_len;
            wr_count = (wr_count > HEADER_LEN) ? wr_count - HEADER_LEN : 0;
         end
         r.readable         = COUNT_W'(rd_count);
         r.writable         = COUNT_W'(wr_count);
         r.packet_remaining = pending_len;
         expected_q.push_back(r);
         return r.status;
      endfunction

      task report_mismatch(string what, logic [REMAIN_W-1:0] got, logic [REMAIN_W-1:0] want);
         errors++;
         $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      endtask

      task check_response(logic [RSP_DATA_W-1:0] beat);
         result_type got;
         result_type want;
         got = result_type'(beat[$bits(result_type)-1:0]);
         if (expected_q.size() == 0) begin
            report_mismatch("response beat with nothing expected", beat[REMAIN_W-1:0], '0);
            return;
         end
         want = expected_q.pop_front();
         if (got.status != want.status) report_mismatch("status", got.status, want.status);
         if (got.read_byte != want.read_byte)
            report_mismatch("read_byte", got.read_byte, want.read_byte);
         if (got.readable != want.readable)
            report_mismatch("readable", got.readable, want.readable);
         if (got.writable != want.writable)
            report_mismatch("writable", got.writable, want.writable);
         if (got.packet_remaining != want.packet_remaining)
            report_mismatch("packet_remaining", got.packet_remaining, want.packet_remaining);
      endtask
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;   // payload_byte, packet_length, zero pad
   logic [REQ_USER_W-1:0]  req_tuser  = '0;   // mode
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0]  rsp_tdata;         // status, read_byte, readable,
                                              // writable, packet_remaining, zero pad
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   ring_scoreboard sb = new();
   bit             idling = 1'b1;
   int unsigned    stall_left = 0;

   packet_framed_byte_ring_top #(
      .BUF_BYTES    (RING_SIZE),
      .HEADER_BYTES (HEADER_LEN)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver back-pressure in random bursts, started only while idling is set.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         if (stall_left == 1) rsp_tready <= 1'b1;
      end else if (idling && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(1, 13);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
   end

   // Returns at the edge that accepted the beat, with valid still high.
   task automatic send_cmd(input mode_type mode, input logic [BYTE_W-1:0] pbyte,
                           input logic [PLEN_W-1:0] plen, output status_type st);
      if (idling && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {{(REQ_DATA_W - PLEN_W - BYTE_W){1'b0}}, plen, pbyte};
      do @(posedge clock); while (!req_tready);
      st = sb.note_request(mode, pbyte, plen);
   endtask

   task automatic push_byte(input logic [BYTE_W-1:0] b);
      status_type st;
      send_cmd(MODE_PUSH, b, PLEN_W'($urandom_range(0, MAX_PLEN)), st);
   endtask

   task automatic pop_byte();
      status_type st;
      send_cmd(MODE_POP, BYTE_W'($urandom), PLEN_W'($urandom_range(0, MAX_PLEN)), st);
   endtask

   task automatic begin_packet(input int unsigned len, output status_type st);
      send_cmd(MODE_BEGIN, BYTE_W'($urandom), PLEN_W'(len), st);
   endtask

   task automatic send_other();
      status_type st;
      send_cmd(MODE_NONE, BYTE_W'($urandom), PLEN_W'($urandom_range(0, MAX_PLEN)), st);
   endtask

   // A whole packet: the header, then its payload if the header went in, with random pops mixed in.
   task automatic send_packet(input int unsigned len, output int unsigned beats);
      status_type st;
      begin_packet(len, st);
      beats = 1;
      if (st == ST_OK) begin
         for (int j = 0; j < len; j++) begin
            if ($urandom_range(0, 3) == 0) begin
               pop_byte();
               beats++;
            end
            push_byte(BYTE_W'($urandom));
            beats++;
         end
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input bit pkt_mode, input bit open);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_PACKET_MODE;
      csr_wdata <= pkt_mode;
      @(posedge clock);
      sb.set_register(CSR_PACKET_MODE, pkt_mode);
      csr_index <= CSR_LINK_OPEN;
      csr_wdata <= open;
      @(posedge clock);
      sb.set_register(CSR_LINK_OPEN, open);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Pops until the ring is empty and, in packet mode, no packet is left open.
   task automatic drain_ring();
      while (sb.held() != 0 || (sb.packet_mode && sb.pending_len != 0)) pop_byte();
   endtask

   task automatic run_stream(input int unsigned count);
      int unsigned r;
      status_type  st;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < ((sb.held() > 48) ? 30 : 50)) push_byte(BYTE_W'($urandom));
         else if (r < 88) pop_byte();
         else if (r < 94) begin_packet($urandom_range(0, MAX_PLEN), st);
         else send_other();
      end
      drain_ring();
   endtask

   // Mostly well-formed packets with random content, mixed with pops and refused commands.
   task automatic run_packets(input int unsigned count);
      int unsigned done;
      int unsigned r;
      int unsigned len;
      int unsigned beats;
      int unsigned room;
      done = 0;
      while (done < count) begin
         r = (sb.held() > 1500) ? 60 : $urandom_range(0, 99);
         // Room for a packet start, counting a header strip that comes before it.
         room = sb.free_bytes();
         if (sb.packet_mode && sb.pending_len == 0 && sb.held() >= HEADER_LEN)
            room += HEADER_LEN;
         if (r < 55) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
            send_packet(len, beats);
            done += beats;
         end else if (r < 80) begin
            repeat ($urandom_range(1, 6)) begin
               pop_byte();
               done++;
            end
         end else if (r < 88) begin
            send_other();
            done++;
         end else if (r < 94 && room + 1 > HEADER_LEN
                      && room - HEADER_LEN + 1 <= MAX_PLEN) begin
            // Just too long to fit, even with the room that a header strip frees.
            len = room - HEADER_LEN + 1 + $urandom_range(0, 30);
            if (len > MAX_PLEN) len = MAX_PLEN;
            send_packet(len, beats);
            done += beats;
         end else begin
            pop_byte();
            done++;
         end
      end
      drain_ring();
   endtask

   initial begin
      logic [REMAIN_W-1:0] big_len;
      status_type          st;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Stream and packet mode with the link closed, then both with it open.
      push_byte(8'hFF);
      pop_byte();
      begin_packet(0, st);
      send_other();
      set_config(1'b1, 1'b0);
      begin_packet(5, st);
      push_byte(8'h00);
      set_config(1'b0, 1'b1);
      push_byte(8'h00);
      push_byte(8'hFF);
      pop_byte();
      pop_byte();
      pop_byte();
      set_config(1'b1, 1'b1);
      begin_packet(0, st);
      begin_packet(2, st);
      push_byte(8'h5A);
      // One byte held, so the longest packet no longer fits.
      begin_packet(MAX_PLEN, st);
      push_byte(8'hA5);
      pop_byte();
      pop_byte();
      pop_byte();

      set_config(1'b0, 1'b1);
      run_stream(80);
      set_config(1'b1, 1'b1);
      run_packets(100);
      set_config(1'b0, 1'b0);
      run_stream(30);
      set_config(1'b1, 1'b0);
      run_packets(30);
      idling = 1'b0;
      set_config(1'b0, 1'b1);
      run_stream(60);
      idling = 1'b1;
      set_config(1'b1, 1'b1);
      run_packets(90);

      // Raw bytes that read as a header with a huge length; the framing never recovers.
      idling = 1'b0;
      set_config(1'b1, 1'b1);
      big_len = 32'hFFFF_E000 | REMAIN_W'($urandom_range(0, 8191));
      for (int i = 0; i < HEADER_LEN; i++) begin
         if (i < LEN_BYTES) push_byte(big_len[8*i +: 8]);
         else push_byte(BYTE_W'($urandom));
      end
      repeat (5) push_byte(BYTE_W'($urandom));
      repeat (6) pop_byte();
      set_config(1'b0, 1'b1);
      run_stream(40);

      // The huge pending length keeps every new header in the ring, so each packet
      // start adds a whole header. The longest packet fits an empty ring exactly, a
      // second one does not, zero-length packets nearly fill the ring and an 11-byte packet fills it to the brim.
      set_config(1'b1, 1'b1);
      begin_packet(MAX_PLEN, st);
      begin_packet(MAX_PLEN, st);
      repeat (407) begin_packet(0, st);
      begin_packet(12, st);
      begin_packet(11, st);
      repeat (11) push_byte(BYTE_W'($urandom));
      push_byte(BYTE_W'($urandom));
      begin_packet(0, st);
      pop_byte();
      push_byte(BYTE_W'($urandom));

      wait_idle();
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
